// ----- design/sawarq_pkg.sv -----
// ----------------------------------------------------------------------------
// sawarq_pkg
// types, constants and command structs shared by the arq retry unit
// ----------------------------------------------------------------------------
package sawarq_pkg;

    localparam int TimeBits = 48;
    localparam int UsPerMs  = 1000;

    typedef logic [TimeBits-1:0] t_time;

    localparam t_time TimeMax = {TimeBits{1'b1}};

    // ceil(2^58 / 1000): a us count below 2^50 times this, shifted right by 58,
    // gives the count in ms exactly
    localparam logic [63:0] MsRecip = 64'h0001_0624_DD2F_1AA0;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_ACK   = 2'd1,
        OP_TICK  = 2'd2,
        OP_RESET = 2'd3
    } t_opcode;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_RETRY  = 2'd1;
    localparam logic [1:0] ACT_DEFER  = 2'd2;
    localparam logic [1:0] ACT_GIVEUP = 2'd3;

    localparam logic [2:0] REG_BASE    = 3'd0;
    localparam logic [2:0] REG_MAXRTY  = 3'd1;
    localparam logic [2:0] REG_JITTER  = 3'd2;
    localparam logic [2:0] REG_JIT_EN  = 3'd3;
    localparam logic [2:0] REG_GRD_EN  = 3'd4;
    localparam logic [2:0] REG_DEFER   = 3'd5;
    localparam logic [2:0] REG_MAXLEN  = 3'd6;

    // event counter slots
    localparam int CNT_SENT   = 0;
    localparam int CNT_ACKED  = 1;
    localparam int CNT_STRAY  = 2;
    localparam int CNT_RETRY  = 3;
    localparam int CNT_GIVEUP = 4;
    localparam int CNT_DEFER  = 5;
    localparam int CNT_NUM    = 6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  seq_in;
        logic [7:0]  frame_len_in;
        t_time       now_time;
        logic [31:0] random_value;
        logic        tx_allowed;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  action;
        logic [7:0]  seq_out;
        logic [7:0]  frame_len;
        logic [1:0]  arq_state;
        logic [31:0] mean_rtt_ms;
        logic [31:0] sent_count;
        logic [31:0] acked_count;
        logic [31:0] stray_ack_count;
        logic [31:0] retry_total;
        logic [31:0] giveup_count;
        logic [31:0] deferred_count;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic div_start; // start shared divider
        logic div_sel;   // 0 jitter modulo, 1 rtt mean
        logic dl_calc;   // compute deadline step (multi-cycle)
        logic commit;    // update state, form result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_busy;
        logic need_jitter;
        logic dl_busy;
    } t_status;

endpackage

// ----- design/stop_and_wait_arq_retry_unit.sv -----
// ----------------------------------------------------------------------------
// stop_and_wait_arq_retry_unit
// sender side of a stop-and-wait arq with exponential backoff and jitter
// ----------------------------------------------------------------------------
// channel | signals                          | direction
// in      | i_valid / o_ready / i_in         | item enters
// out     | o_valid / i_ready / o_out        | result leaves
// cfg     | i_cfg_we / i_cfg_idx / i_cfg_data| register write
//
// result valid after the 3-step deadline pipeline, which also does the rtt us to ms,
// and a 32-step pass of the shared divider for the mean rtt; when jitter is added
// a second divider pass for the jitter modulo runs before the deadline pipeline
// one transaction at a time; input ready only when idle, in the cycle after output
// synchronous active-low reset clears protocol state, counters and config
// output stall holds the result and the sequencer in its output state
module stop_and_wait_arq_retry_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sawarq_pkg::t_in_item  i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sawarq_pkg::t_out_item o_out,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);
    import sawarq_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    // sequencer
    sawarq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // state, arithmetic and result
    sawarq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (o_out)
    );
endmodule

// ----- design/sawarq_div.sv -----
// ----------------------------------------------------------------------------
// sawarq_div
// 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sawarq_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic [5:0]  r_cnt;
    logic [31:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [32:0] w_trial;
    logic [32:0] w_shift;

    assign w_shift = {r_r, r_q[31]};
    assign w_trial = w_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_cnt != '0) begin
            if (!w_trial[32]) begin
                r_r <= w_trial[31:0];
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_r <= w_shift[31:0];
                r_q <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule

// ----- design/sawarq_dp.sv -----
// ----------------------------------------------------------------------------
// sawarq_dp
// datapath: config, protocol state, counters, deadline arithmetic, divider
// ----------------------------------------------------------------------------
module sawarq_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    input  sawarq_pkg::t_in_item  i_item,
    input  sawarq_pkg::t_cmd      i_cmd,
    output sawarq_pkg::t_status   o_sts,
    output sawarq_pkg::t_out_item o_res
);
    import sawarq_pkg::*;

    // configuration
    logic [15:0] r_base, r_jit, r_defer;
    logic [3:0]  r_maxrty;
    logic        r_jit_en, r_grd_en;
    logic [7:0]  r_maxlen;

    // protocol state
    logic [1:0]  r_pst;
    logic [7:0]  r_pseq, r_plen;
    logic [3:0]  r_rtry;
    t_time       r_dl, r_stime;
    logic [31:0] r_cnt [CNT_NUM];
    logic [31:0] r_rsum, r_rsmp;

    // result flags of the last commit
    logic        r_accepted;
    logic [1:0]  r_action;

    // captured item and per-item work registers
    t_in_item    r_it;
    logic [31:0] r_jitv;   // jitter in ms
    logic [1:0]  r_kind;   // 0 none, 1 timeout-deadline, 2 defer-deadline
    logic [3:0]  r_shift;
    logic [37:0] r_ms;     // timeout in ms
    logic [47:0] r_us;     // ms * 1000 partial (fits 38+10)
    logic [TimeBits:0] r_sum;
    logic [1:0]  r_dl_cnt;
    t_time       w_newdl;

    // rtt us -> ms by reciprocal, one 16-bit slice of the constant per step
    logic [64:0] r_racc;
    logic [15:0] w_rchunk;
    logic [63:0] w_rprod;

    logic [31:0] w_quo, w_rem;
    logic        w_div_busy;
    logic [31:0] w_num, w_den;

    // decisions for the captured item
    logic w_waiting, w_send_ok, w_ack_ok, w_due, w_giveup, w_defer, w_retry;
    logic [3:0] w_next_rtry, w_sh_raw;

    logic [TimeBits-1:0] w_rtt_us;
    logic [31:0]         w_rtt_ms;

    assign w_waiting  = (r_pst == ST_WAIT);
    assign w_send_ok  = !w_waiting && (r_it.frame_len_in != '0)
                        && (r_it.frame_len_in <= r_maxlen);
    assign w_ack_ok   = w_waiting && (r_it.seq_in == r_pseq);
    assign w_due      = w_waiting && (r_it.now_time >= r_dl);
    assign w_giveup   = w_due && (r_rtry >= r_maxrty);
    assign w_defer    = w_due && !w_giveup && r_grd_en && !r_it.tx_allowed;
    assign w_retry    = w_due && !w_giveup && !w_defer;
    assign w_next_rtry = r_rtry + 4'd1;
    assign w_sh_raw   = (r_it.opcode == OP_SEND) ? 4'd0 : w_next_rtry;

    always_comb begin
        o_sts.need_jitter = r_jit_en && (r_jit != '0) &&
            (((r_it.opcode == OP_SEND) && w_send_ok) ||
             ((r_it.opcode == OP_TICK) && w_retry));
        o_sts.div_busy = w_div_busy;
        o_sts.dl_busy  = (r_dl_cnt != '0);
    end

    assign w_num = i_cmd.div_sel ? r_rsum : r_it.random_value;
    assign w_den = i_cmd.div_sel ? r_rsmp : {16'd0, r_jit};

    sawarq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= 16'd2000;
            r_maxrty <= 4'd5;
            r_jit    <= 16'd1000;
            r_jit_en <= 1'b0;
            r_grd_en <= 1'b0;
            r_defer  <= 16'd250;
            r_maxlen <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE:   r_base   <= i_cfg_data;
                REG_MAXRTY: r_maxrty <= i_cfg_data[3:0];
                REG_JITTER: r_jit    <= i_cfg_data;
                REG_JIT_EN: r_jit_en <= i_cfg_data[0];
                REG_GRD_EN: r_grd_en <= i_cfg_data[0];
                REG_DEFER:  r_defer  <= i_cfg_data;
                REG_MAXLEN: r_maxlen <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // deadline pipeline: stage 0 ms, 1 us product, 2 add, then combinational saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_cnt <= '0;
        end else if (i_cmd.dl_calc) begin
            r_dl_cnt <= 2'd3;
        end else if (r_dl_cnt != '0) begin
            r_dl_cnt <= r_dl_cnt - 2'd1;
        end
    end

    // rtt slices follow the deadline steps: lowest slice at dl_calc, top at the last step
    always_comb begin
        case (r_dl_cnt)
            2'd3:    w_rchunk = MsRecip[31:16];
            2'd2:    w_rchunk = MsRecip[47:32];
            2'd1:    w_rchunk = MsRecip[63:48];
            default: w_rchunk = MsRecip[15:0];
        endcase
    end

    assign w_rtt_us = r_it.now_time - r_stime;
    assign w_rprod  = w_rtt_us * w_rchunk;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_it <= i_item;
            r_jitv <= '0;
        end
        if (i_cmd.div_start && !i_cmd.div_sel) begin
            r_jitv <= '0;
        end
        if (!w_div_busy && !i_cmd.div_sel && o_sts.need_jitter && !i_cmd.div_start
            && !i_cmd.load) begin
            r_jitv <= w_rem;
        end
        if (i_cmd.dl_calc) begin
            r_shift <= (w_sh_raw > r_maxrty) ? r_maxrty : w_sh_raw;
            r_kind  <= w_defer ? 2'd2 : 2'd1;
            r_racc  <= {1'b0, w_rprod};
        end else if (r_dl_cnt != '0) begin
            r_racc  <= (r_racc >> 16) + {1'b0, w_rprod};
        end
        case (r_dl_cnt)
            2'd3: r_ms <= (r_kind == 2'd2) ? {22'd0, r_defer}
                        : (({22'd0, r_base} << r_shift)
                           + (o_sts.need_jitter ? {6'd0, r_jitv} : 38'd0));
            2'd2: r_us <= 48'(r_ms * 38'(UsPerMs));
            2'd1: r_sum <= {1'b0, r_it.now_time} + (TimeBits+1)'(r_us);
            default: ;
        endcase
    end

    // saturation (r_us fits 48 bits; wider product bits not possible)
    assign w_newdl = r_sum[TimeBits] ? TimeMax : r_sum[TimeBits-1:0];

    // r_racc holds the product shifted right by 48, ten more bits give ms
    assign w_rtt_ms = r_racc[41:10];

    // commit of state updates and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pst      <= ST_IDLE;
            r_pseq     <= '0;
            r_plen     <= '0;
            r_rtry     <= '0;
            r_dl       <= '0;
            r_stime    <= '0;
            r_rsum     <= '0;
            r_rsmp     <= '0;
            r_accepted <= 1'b0;
            r_action   <= ACT_NONE;
            for (int k = 0; k < CNT_NUM; k++) r_cnt[k] <= '0;
        end else if (i_cmd.commit) begin
            r_accepted <= 1'b0;
            r_action   <= ACT_NONE;
            case (t_opcode'(r_it.opcode))
                OP_SEND: if (w_send_ok) begin
                    r_plen  <= r_it.frame_len_in;
                    r_pseq  <= r_it.seq_in;
                    r_rtry  <= '0;
                    r_pst   <= ST_WAIT;
                    r_stime <= r_it.now_time;
                    r_dl    <= w_newdl;
                    r_cnt[CNT_SENT] <= r_cnt[CNT_SENT] + 32'd1;
                    r_accepted <= 1'b1;
                end
                OP_ACK: if (!w_ack_ok) begin
                    r_cnt[CNT_STRAY] <= r_cnt[CNT_STRAY] + 32'd1;
                end else begin
                    if (r_it.now_time > r_stime) begin
                        r_rsum <= r_rsum + w_rtt_ms;
                        r_rsmp <= r_rsmp + 32'd1;
                    end
                    r_cnt[CNT_ACKED] <= r_cnt[CNT_ACKED] + 32'd1;
                    r_pst  <= ST_DONE;
                    r_plen <= '0;
                    r_accepted <= 1'b1;
                end
                OP_TICK: begin
                    if (w_giveup) begin
                        r_pst <= ST_FAIL;
                        r_cnt[CNT_GIVEUP] <= r_cnt[CNT_GIVEUP] + 32'd1;
                        r_action <= ACT_GIVEUP;
                    end else if (w_defer) begin
                        r_dl <= w_newdl;
                        r_cnt[CNT_DEFER] <= r_cnt[CNT_DEFER] + 32'd1;
                        r_action <= ACT_DEFER;
                    end else if (w_retry) begin
                        r_rtry <= w_next_rtry;
                        r_cnt[CNT_RETRY] <= r_cnt[CNT_RETRY] + 32'd1;
                        r_dl <= w_newdl;
                        r_action <= ACT_RETRY;
                    end
                end
                default: begin
                    r_pst   <= ST_IDLE;
                    r_pseq  <= '0;
                    r_plen  <= '0;
                    r_rtry  <= '0;
                    r_dl    <= '0;
                    r_stime <= '0;
                end
            endcase
        end
    end

    // mean rtt is the divider quotient, valid once the divider finishes after commit
    always_comb begin
        o_res.accepted        = r_accepted;
        o_res.action          = r_action;
        o_res.seq_out         = r_pseq;
        o_res.frame_len       = r_plen;
        o_res.arq_state       = r_pst;
        o_res.mean_rtt_ms     = (r_rsmp == '0) ? 32'd0 : w_quo;
        o_res.sent_count      = r_cnt[CNT_SENT];
        o_res.acked_count     = r_cnt[CNT_ACKED];
        o_res.stray_ack_count = r_cnt[CNT_STRAY];
        o_res.retry_total     = r_cnt[CNT_RETRY];
        o_res.giveup_count    = r_cnt[CNT_GIVEUP];
        o_res.deferred_count  = r_cnt[CNT_DEFER];
    end
endmodule

// ----- design/sawarq_ctrl.sv -----
// ----------------------------------------------------------------------------
// sawarq_ctrl
// sequencer for one transaction: jitter divide, deadline, commit, mean divide
// ----------------------------------------------------------------------------
module sawarq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  sawarq_pkg::t_status i_sts,
    output sawarq_pkg::t_cmd    o_cmd
);
    import sawarq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_JDIV  = 7'b0000010,
        S_JWAIT = 7'b0000100,
        S_DL    = 7'b0001000,
        S_DLW   = 7'b0010000,
        S_MDIV  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st  = r_st;
        o_cmd = '0;
        case (r_st)
            S_IDLE: if (i_valid) begin
                o_cmd.load = 1'b1;
                n_st = S_JDIV;
            end
            S_JDIV: begin
                if (i_sts.need_jitter) begin
                    o_cmd.div_start = 1'b1;
                end
                n_st = S_JWAIT;
            end
            S_JWAIT: if (!i_sts.div_busy) begin
                o_cmd.dl_calc = 1'b1;
                n_st = S_DL;
            end
            S_DL: n_st = S_DLW;
            S_DLW: if (!i_sts.dl_busy) begin
                o_cmd.commit = 1'b1;
                n_st = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_st = S_OUT;
            end
            S_OUT: begin
                o_cmd.div_sel = 1'b1;
                if (!i_sts.div_busy && i_ready) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT) && !i_sts.div_busy;
endmodule
